/* src/dtwc_pkg.sv */
`default_nettype none

package dtwc_pkg;

    // Field widths fixed by the interface.
    localparam int CFG_W   = 11;
    localparam int LOCAL_W = 16;
    localparam int WARP_W  = 32;

    // Reset value of the row width register.
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Defaults for the top-level parameters.
    localparam int MAX_COLS_DEF  = 1024;
    localparam int COST_BITS_DEF = 32;

    // Depths of the cell queue and the result queue.
    localparam int CELL_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH  = 4;

endpackage

`default_nettype wire

/* src/dtwc_fifo.sv */
`default_nettype none

module dtwc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    // Writes are dropped when full and reads when empty.
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill-count update, pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* src/dtwc_front.sv */
`default_nettype none

module dtwc_front
    import dtwc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [CFG_W-1:0]            cols_in_use,
    input  wire logic                        accept,
    input  wire logic                        starts_pair,
    input  wire logic                        last_cell,
    output logic      [$clog2(MAX_COLS)-1:0] cell_col,
    output logic                             cell_first_row
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int WID_W = $clog2(MAX_COLS + 1);
    localparam int CMP_W = (WID_W > CFG_W) ? WID_W : CFG_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic             first_reg, first_next;
    logic [CMP_W-1:0] row_width;
    logic [COL_W-1:0] col_start;
    logic             first_start;
    logic             wrap_before;
    logic [CMP_W-1:0] col_inc;
    logic             wrap_after;

    // Effective row width: zero acts as one, large values clamp to the row store.
    always_comb
    begin
        if (cols_in_use == '0)
        begin
            row_width = CMP_W'(1);
        end
        else if (CMP_W'(cols_in_use) > CMP_W'(MAX_COLS))
        begin
            row_width = CMP_W'(MAX_COLS);
        end
        else
        begin
            row_width = CMP_W'(cols_in_use);
        end
    end

    // Place the beat in the matrix: start mark first, then a row that the
    // width change has already ended.
    always_comb
    begin
        col_start   = starts_pair ? '0 : col_reg;
        first_start = starts_pair ? 1'b1 : first_reg;
        wrap_before = (CMP_W'(col_start) >= row_width);
        cell_col       = wrap_before ? '0 : col_start;
        cell_first_row = wrap_before ? 1'b0 : first_start;
        col_inc     = CMP_W'(cell_col) + CMP_W'(1);
        wrap_after  = (col_inc >= row_width);
    end

    // Position of the next cell.
    always_comb
    begin
        col_next   = col_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (last_cell)
            begin
                col_next   = '0;
                first_next = 1'b1;
            end
            else if (wrap_after)
            begin
                col_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                col_next   = col_inc[COL_W-1:0];
                first_next = cell_first_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

/* src/dtwc_back.sv */
`default_nettype none

module dtwc_back
    import dtwc_pkg::*;
#(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int COST_BITS = COST_BITS_DEF,
    parameter int OUT_DEPTH = RES_Q_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    input  wire logic [LOCAL_W-1:0]              q_local,
    input  wire logic [$clog2(MAX_COLS)-1:0]     q_col,
    input  wire logic                            q_first_row,
    input  wire logic                            q_last,
    output logic                                 q_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]  res_count,
    output logic                                 res_push,
    output logic      [WARP_W-1:0]               res_cost
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam int EXT_W = (COST_BITS > WARP_W) ? COST_BITS : WARP_W;
    localparam logic [COST_BITS-1:0] COST_INF = '1;

    // Row store: previous row's accumulated costs, one read port, one write port.
    logic [COST_BITS-1:0] row_mem [MAX_COLS];

    logic                 s1_valid_reg, s1_valid_next;
    logic [LOCAL_W-1:0]   s1_local_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_first_reg;
    logic                 s1_last_reg;
    logic [COST_BITS-1:0] rdata_reg;
    logic                 fwd_hit_reg;
    logic [COST_BITS-1:0] fwd_data_reg;
    logic [COST_BITS-1:0] left_reg;
    logic [COST_BITS-1:0] diag_reg;

    logic [COST_BITS-1:0] up_cost;
    logic [COST_BITS-1:0] diag_cost;
    logic [COST_BITS-1:0] left_cost;
    logic [COST_BITS-1:0] best;
    logic [COST_BITS:0]   sum;
    logic [COST_BITS-1:0] cost;
    logic [EXT_W-1:0]     cost_ext;

    // A beat leaves the queue only when the result queue has room for
    // everything already in flight.
    assign q_pop = !q_empty && ((OCW + 1)'(res_count) + (OCW + 1)'(s1_valid_reg)
                                < (OCW + 1)'(OUT_DEPTH));
    assign s1_valid_next = q_pop;

    // Neighbor costs: the first column sees infinity on the left, and the
    // origin sees a zero diagonal.
    always_comb
    begin
        if (s1_first_reg)
        begin
            up_cost = COST_INF;
        end
        else if (fwd_hit_reg)
        begin
            up_cost = fwd_data_reg;
        end
        else
        begin
            up_cost = rdata_reg;
        end
        if (s1_col_reg == '0)
        begin
            left_cost = COST_INF;
            diag_cost = s1_first_reg ? '0 : COST_INF;
        end
        else
        begin
            left_cost = left_reg;
            diag_cost = diag_reg;
        end
    end

    // Three-way minimum and saturating add.
    always_comb
    begin
        best = up_cost;
        if (diag_cost < best)
        begin
            best = diag_cost;
        end
        if (left_cost < best)
        begin
            best = left_cost;
        end
        sum  = (COST_BITS + 1)'(s1_local_reg) + (COST_BITS + 1)'(best);
        cost = (sum >= (COST_BITS + 1)'(COST_INF)) ? COST_INF : sum[COST_BITS-1:0];
    end

    // Result word saturates to all ones.
    assign cost_ext = EXT_W'(cost);
    assign res_cost = (cost_ext >= EXT_W'({WARP_W{1'b1}})) ? '1 : cost_ext[WARP_W-1:0];
    assign res_push = s1_valid_reg && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage payload; a read of the column being written this edge is forwarded.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_local_reg <= q_local;
            s1_col_reg   <= q_col;
            s1_first_reg <= q_first_row;
            s1_last_reg  <= q_last;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == q_col);
            fwd_data_reg <= cost;
        end
        if (s1_valid_reg)
        begin
            left_reg <= cost;
            diag_reg <= up_cost;
        end
    end

    // Row store access.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            row_mem[s1_col_reg] <= cost;
        end
        if (q_pop)
        begin
            rdata_reg <= row_mem[q_col];
        end
    end

endmodule

`default_nettype wire

/* src/dtw_cost_accumulator.sv */
`default_nettype none

// Dynamic time warping cost accumulator. Feed the cost matrix one cell per beat
// in row-major order, local_cost carrying the distance of that cell; mark the
// first cell of a comparison with starts_pair and the final one with last_cell,
// which yields one warp_cost beat (all ones means infinite or saturated). The
// block takes one cell per clock cycle while the cell queue is not full, bounded
// by the single read port of the row store that holds the previous row. A cell
// is registered in the cell queue, where its row store read is issued, and then
// in the accumulator stage, which pushes the result of a last cell into the
// result queue. A short queue separates cell intake from accumulation and
// another holds results, so either side may stall without stopping the other.
// cols_in_use sets the cells per row and is to be written only while no
// comparison is in progress; zero acts as one and values above MAX_COLS act
// as MAX_COLS. The row store needs no clearing after reset.
module dtw_cost_accumulator
    import dtwc_pkg::*;
#(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int COST_BITS = COST_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [LOCAL_W-1:0] local_cost,
    input  wire logic               starts_pair,
    input  wire logic               last_cell,
    output logic                    empty,
    input  wire logic               pop,
    output logic      [WARP_W-1:0]  warp_cost
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CELL_W = LOCAL_W + COL_W + 2;
    localparam int RCW    = $clog2(RES_Q_DEPTH + 1);

    logic [CFG_W-1:0]  cols_in_use_reg, cols_in_use_next;
    logic              accept;
    logic [COL_W-1:0]  cell_col;
    logic              cell_first_row;
    logic [CELL_W-1:0] cell_wr_data;
    logic [CELL_W-1:0] cell_rd_data;
    logic              cell_empty;
    logic [$clog2(CELL_Q_DEPTH+1)-1:0] cell_count;
    logic              cell_pop;
    logic              res_push;
    logic [WARP_W-1:0] res_cost;
    logic [RCW-1:0]    res_count;
    logic              res_full;

    // Row width register.
    assign cols_in_use_next = cfg_wr_en ? cfg_wr_data : cols_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_in_use_reg <= CFG_RESET;
        end
        else
        begin
            cols_in_use_reg <= cols_in_use_next;
        end
    end

    assign accept = push && !full;

    // Intake: place each cell in the matrix.
    dtwc_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cols_in_use    (cols_in_use_reg),
        .accept         (accept),
        .starts_pair    (starts_pair),
        .last_cell      (last_cell),
        .cell_col       (cell_col),
        .cell_first_row (cell_first_row)
    );

    assign cell_wr_data = {local_cost, cell_col, cell_first_row, last_cell};

    // Queue of placed cells.
    dtwc_fifo #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_Q_DEPTH)
    ) u_cell_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (cell_wr_data),
        .rd_en   (cell_pop),
        .rd_data (cell_rd_data),
        .full    (full),
        .empty   (cell_empty),
        .count   (cell_count)
    );

    // Accumulation over the row store.
    dtwc_back #(
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS),
        .OUT_DEPTH (RES_Q_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (cell_empty),
        .q_local     (cell_rd_data[CELL_W-1 -: LOCAL_W]),
        .q_col       (cell_rd_data[COL_W+1:2]),
        .q_first_row (cell_rd_data[1]),
        .q_last      (cell_rd_data[0]),
        .q_pop       (cell_pop),
        .res_count   (res_count),
        .res_push    (res_push),
        .res_cost    (res_cost)
    );

    // Result queue; the accumulator never pushes into it when full.
    dtwc_fifo #(
        .WIDTH (WARP_W),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push && !res_full),
        .wr_data (res_cost),
        .rd_en   (pop),
        .rd_data (warp_cost),
        .full    (res_full),
        .empty   (empty),
        .count   (res_count)
    );

    // Fill level of the cell queue is not needed outside it.
    logic unused_cell_count;
    assign unused_cell_count = ^cell_count;

endmodule

`default_nettype wire

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtwc_pkg::*;

    localparam int ROW_MAX      = MAX_COLS_DEF;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam int DIRECTED_N   = 17;

    localparam logic [WARP_W-1:0] COST_INF = '1;

    // Shapes of the random cell groups.
    typedef enum int {
        GRP_FULL,
        GRP_CUT,
        GRP_NOISE
    } group_e;

    // Pop patterns of the result side.
    typedef enum int {
        SINK_EAGER,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PULSED
    } sink_mode_e;

    // One row of the directed stimulus; want is used only where typed is set.
    typedef struct packed {
        logic [LOCAL_W-1:0] lc;
        logic               sp;
        logic               lcell;
        logic               typed;
        logic [WARP_W-1:0]  want;
    } cell_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               push;
    logic               full;
    logic [LOCAL_W-1:0] local_cost;
    logic               starts_pair;
    logic               last_cell;
    logic               empty;
    logic               pop;
    logic [WARP_W-1:0]  warp_cost;

    dtw_cost_accumulator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .local_cost  (local_cost),
        .starts_pair (starts_pair),
        .last_cell   (last_cell),
        .empty       (empty),
        .pop         (pop),
        .warp_cost   (warp_cost)
    );

    always #5 clk = ~clk;

    // Shadow copy of the accumulator state.
    logic [WARP_W-1:0] prev_row [ROW_MAX];
    int unsigned       col_pos;
    logic [WARP_W-1:0] left_acc;
    logic [WARP_W-1:0] diag_acc;
    bit                first_row;
    logic [CFG_W-1:0]  width_reg;

    // Total costs still owed by the block, oldest first.
    logic [WARP_W-1:0] warp_expected [$];

    int unsigned fail_count  = 0;
    int unsigned burst_left  = 0;
    bit          steady_feed = 1'b0;
    bit          hold_req    = 1'b0;
    cell_row_t   directed_cells [DIRECTED_N];

    // Zero acts as one and anything above the row store acts as its size.
    function automatic int unsigned row_len();
        if (width_reg == '0)
            return 1;
        if (width_reg > ROW_MAX)
            return ROW_MAX;
        return int'(width_reg);
    endfunction

    function automatic void restart_matrix();
        col_pos   = 0;
        left_acc  = COST_INF;
        diag_acc  = '0;
        first_row = 1'b1;
    endfunction

    function automatic void next_row();
        col_pos   = 0;
        left_acc  = COST_INF;
        diag_acc  = COST_INF;
        first_row = 1'b0;
    endfunction

    // Accumulate one cell; returns 1 when the cell closes a matrix.
    function automatic bit accumulate_cell(input logic [LOCAL_W-1:0] lc, input bit sp,
                                           input bit lcell, output logic [WARP_W-1:0] total);
        int unsigned       w;
        logic [WARP_W-1:0] up;
        logic [WARP_W-1:0] best;
        logic [WARP_W:0]   sum;
        w = row_len();
        if (sp)
            restart_matrix();
        if (col_pos >= w)
            next_row();
        up   = first_row ? COST_INF : prev_row[col_pos];
        best = up;
        if (diag_acc < best)
            best = diag_acc;
        if (left_acc < best)
            best = left_acc;
        // Infinity is sticky and any sum reaching all ones saturates there.
        sum   = {1'b0, best} + (WARP_W + 1)'(lc);
        total = (best == COST_INF || sum >= {1'b0, COST_INF}) ? COST_INF : sum[WARP_W-1:0];
        prev_row[col_pos] = total;
        diag_acc = up;
        left_acc = total;
        col_pos++;
        if (col_pos >= w)
            next_row();
        if (lcell)
            restart_matrix();
        return lcell;
    endfunction

    // Local costs lean toward the extremes and toward small values.
    function automatic logic [LOCAL_W-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return LOCAL_W'($urandom_range(0, 15));
            default: return LOCAL_W'($urandom);
        endcase
    endfunction

    task automatic report_fail(input string what, input logic [WARP_W-1:0] want,
                               input logic [WARP_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endtask

    // Offer one cell beat and wait until it is taken; gaps fall between bursts.
    task automatic send_cell(input logic [LOCAL_W-1:0] lc, input bit sp, input bit lcell,
                             input bit typed, input logic [WARP_W-1:0] want);
        int unsigned       gap;
        logic [WARP_W-1:0] total;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (!steady_feed && gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push        <= 1'b1;
        local_cost  <= lc;
        starts_pair <= sp;
        last_cell   <= lcell;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
        if (accumulate_cell(lc, sp, lcell, total))
            warp_expected.push_back(typed ? want : total);
    endtask

    // Change the row width once the block has gone quiet.
    task automatic set_row_width(input logic [CFG_W-1:0] value);
        push <= 1'b0;
        while (warp_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        width_reg = value;
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    // Random groups: mostly whole matrices, some cut short, some noise.
    // Every group ends on a last mark, so a phase ends at the start position.
    task automatic random_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned roll;
        int unsigned cells;
        int unsigned w;
        group_e      shape;
        bit          sp;
        bit          lcell;
        sent = 0;
        w    = row_len();
        while (sent < budget) begin
            roll  = $urandom_range(0, 9);
            shape = (roll < 7) ? GRP_FULL : ((roll == 7) ? GRP_CUT : GRP_NOISE);
            case (shape)
                GRP_FULL: cells = $urandom_range(1, 5) * w;
                GRP_CUT: cells = $urandom_range(1, 5 * w);
                default: cells = $urandom_range(1, 6);
            endcase
            for (int unsigned i = 0; i < cells; i++) begin
                if (shape == GRP_NOISE) begin
                    sp    = ($urandom_range(0, 2) == 0);
                    lcell = (i == cells - 1) || ($urandom_range(0, 2) == 0);
                end else begin
                    sp    = (i == 0) && ($urandom_range(0, 3) != 0);
                    lcell = (i == cells - 1);
                end
                send_cell(pick_cost(), sp, lcell, 1'b0, '0);
            end
            sent += cells;
        end
    endtask

    // Stimulus and end of run.
    initial begin : stimulus
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        push        = 1'b0;
        local_cost  = '0;
        starts_pair = 1'b0;
        last_cell   = 1'b0;
        width_reg   = CFG_RESET;
        restart_matrix();

        // Directed cells at the reset width of 1024.
        directed_cells = '{
            '{16'd0,     1'b0, 1'b1, 1'b1, 32'd0},
            '{16'hFFFF,  1'b1, 1'b1, 1'b1, 32'd65535},
            '{16'hFFFF,  1'b0, 1'b0, 1'b0, 32'd0},
            '{16'hFFFF,  1'b0, 1'b1, 1'b1, 32'd131070},
            '{16'd7,     1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd9,     1'b1, 1'b1, 1'b1, 32'd9},
            '{16'd12,    1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd0,     1'b0, 1'b0, 1'b0, 32'd0},
            '{16'hFFFF,  1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd3,     1'b0, 1'b1, 1'b0, 32'd0},
            '{16'd1,     1'b1, 1'b0, 1'b0, 32'd0},
            '{16'd40000, 1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd2,     1'b0, 1'b0, 1'b0, 32'd0},
            '{16'hFFFF,  1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd0,     1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd123,   1'b0, 1'b0, 1'b0, 32'd0},
            '{16'd555,   1'b0, 1'b0, 1'b0, 32'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_cell(directed_cells[i].lc, directed_cells[i].sp, directed_cells[i].lcell,
                      directed_cells[i].typed, directed_cells[i].want);

        // The matrix is left at column 7; narrowing the row to 3 wraps it at once.
        set_row_width(11'd3);
        for (int i = 0; i < 4; i++)
            send_cell(pick_cost(), 1'b0, i == 3, 1'b0, '0);
        random_phase(80);

        // One cell per row with frequent results while the result side holds off,
        // so both queues fill and the cell side sees full.
        set_row_width(11'd1);
        steady_feed = 1'b1;
        hold_req    = 1'b1;
        for (int i = 0; i < 60; i++)
            send_cell(pick_cost(), $urandom_range(0, 7) == 0,
                      (i == 59) || ($urandom_range(0, 1) == 1), 1'b0, '0);
        steady_feed = 1'b0;

        set_row_width(11'd0);
        random_phase(40);

        // Widest register value acts as the full row store: one full row and a bit more.
        set_row_width(11'd2047);
        for (int i = 0; i < ROW_MAX + 5; i++)
            send_cell(pick_cost(), i == 0, i == ROW_MAX + 4, 1'b0, '0);

        set_row_width(11'd2);
        random_phase(80);
        repeat (2) begin
            set_row_width(CFG_W'($urandom_range(4, 12)));
            random_phase(60);
        end

        push <= 1'b0;
        while (warp_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[dtw_cost_accumulator] OK");
        else
            $display("[dtw_cost_accumulator] ERROR");
        $finish;
    end

    // Result side: checks each accepted beat and stalls on its own pattern.
    initial begin : result_sink
        sink_mode_e        mode;
        int unsigned       mode_left;
        int unsigned       tick;
        logic [WARP_W-1:0] want;
        pop       = 1'b0;
        mode      = SINK_EAGER;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                if (warp_expected.size() == 0) begin
                    report_fail("warp_cost beat with nothing expected", 'x, warp_cost);
                end else begin
                    want = warp_expected.pop_front();
                    if (warp_cost !== want)
                        report_fail("warp_cost mismatch", want, warp_cost);
                end
            end
            if (hold_req) begin
                // Long hold-off, counted here, while cells keep coming.
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    SINK_EAGER: pop <= 1'b1;
                    SINK_COIN: pop <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: pop <= ($urandom_range(0, 4) == 0);
                    default: pop <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[dtw_cost_accumulator] ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/dtwc_pkg.sv
src/dtwc_fifo.sv
src/dtwc_front.sv
src/dtwc_back.sv
src/dtw_cost_accumulator.sv
dv/tb.sv
